// File: rtl/phd_pkg.sv
package phd_pkg;

    // Field widths of the item ports.
    localparam int COORD_BITS = 21;
    localparam int CELL_BITS  = 8;
    localparam int OUT_W      = 31;

    // Configuration port.
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 2'd2;

    // Arithmetic widths derived from the field widths.
    localparam int AXES    = 3;
    localparam int ROW_W   = AXES * COORD_BITS;
    localparam int DPOS_W  = COORD_BITS + 1;
    localparam int DCELL_W = CELL_BITS + 1;
    localparam int PROD_W  = COORD_BITS + DCELL_W;
    localparam int DISP_W  = ((PROD_W > DPOS_W) ? PROD_W : DPOS_W) + 2;
    localparam int SQ_W    = 2 * DISP_W;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 3;

    // Pipeline depth: difference, products, row sums, squares, total, then one
    // stage per root bit.
    localparam int FRONT_STAGES = 5;
    localparam int PIPE_LATENCY = FRONT_STAGES + ROOT_W;

    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_stage_t;

endpackage

// File: rtl/phd_front.sv
module phd_front
    import phd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] dest_pos [AXES],
    input  logic signed [CELL_BITS-1:0]  dest_cell [AXES],
    input  logic signed [COORD_BITS-1:0] src_pos [AXES],
    input  logic signed [CELL_BITS-1:0]  src_cell [AXES],
    input  logic [CFG_W-1:0]             lattice_row [AXES],
    output root_stage_t                  front_out
);

    logic [FRONT_STAGES-1:0] valid_reg;

    logic signed [DPOS_W-1:0]  dpos_reg [AXES];
    logic signed [DCELL_W-1:0] dcell_reg [AXES];
    logic signed [DPOS_W-1:0]  dpos2_reg [AXES];
    logic signed [PROD_W-1:0]  prod_reg [AXES][AXES];
    logic signed [DISP_W-1:0]  disp_reg [AXES];
    logic [SUM_W-1:0]          sq_reg [AXES];
    logic [SUM_W-1:0]          sum_reg;

    logic [ROW_W-1:0]           row_ext [AXES];
    logic signed [COORD_BITS-1:0] entry [AXES][AXES];
    logic signed [DISP_W-1:0]   disp_next [AXES];
    logic [DISP_W-1:0]          mag [AXES];
    logic [SQ_W-1:0]            sq_next [AXES];

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            // Bits beyond the register read as zero before sign extension.
            row_ext[r] = ROW_W'(lattice_row[r]);
            for (int c = 0; c < AXES; c++)
            begin
                entry[r][c] = signed'(row_ext[r][c*COORD_BITS +: COORD_BITS]);
            end
            disp_next[r] = DISP_W'(dpos2_reg[r]) + DISP_W'(prod_reg[r][0])
                         + DISP_W'(prod_reg[r][1]) + DISP_W'(prod_reg[r][2]);
            mag[r]       = disp_reg[r][DISP_W-1] ? DISP_W'(-disp_reg[r])
                                                 : DISP_W'(disp_reg[r]);
            sq_next[r]   = SQ_W'(mag[r]) * SQ_W'(mag[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < AXES; r++)
        begin
            dpos_reg[r]  <= DPOS_W'(dest_pos[r]) - DPOS_W'(src_pos[r]);
            dcell_reg[r] <= DCELL_W'(dest_cell[r]) - DCELL_W'(src_cell[r]);
            dpos2_reg[r] <= dpos_reg[r];
            for (int c = 0; c < AXES; c++)
            begin
                prod_reg[r][c] <= PROD_W'(entry[r][c]) * PROD_W'(dcell_reg[c]);
            end
            disp_reg[r] <= disp_next[r];
            sq_reg[r]   <= SUM_W'(sq_next[r]);
        end
        sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_comb
    begin
        front_out.valid = valid_reg[FRONT_STAGES-1];
        front_out.rad   = sum_reg;
        front_out.rem   = '0;
        front_out.root  = '0;
    end

endmodule

// File: rtl/phd_root_cell.sv
module phd_root_cell
    import phd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  root_stage_t cell_in,
    output root_stage_t cell_out
);

    logic              valid_reg;
    logic [SUM_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [SUM_W-1:0]  rad_next;

    // One restoring step: bring down two radicand bits and try a one bit.
    always_comb
    begin
        rem_shift = {cell_in.rem[REM_W-3:0], cell_in.rad[SUM_W-1 -: 2]};
        trial     = REM_W'({cell_in.root, 2'b01});
        fits      = (rem_shift >= trial);
        rem_next  = fits ? (rem_shift - trial) : rem_shift;
        root_next = {cell_in.root[ROOT_W-2:0], fits};
        rad_next  = {cell_in.rad[SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        cell_out.valid = valid_reg;
        cell_out.rad   = rad_reg;
        cell_out.rem   = rem_reg;
        cell_out.root  = root_reg;
    end

endmodule

// File: rtl/periodic_lattice_hop_distance_core.sv
// Periodic lattice hop distance. Each item carries two molecule centers
// (signed Q10.10) and the lattice cells they sit in; the block returns the
// floor of the Euclidean length of the periodic displacement in unsigned Q.10.
// The unit is fully pipelined: busy stays low, an item may be started in every
// cycle, and each result appears on hop_length with done high for exactly one
// cycle. The receiver cannot stall the block, so it must take every result in
// the cycle it is shown. The pipeline is five arithmetic stages followed by a
// chain of 32 square root cells, one root bit per cell. Lattice rows must be
// written through cfg_we, cfg_index and cfg_data only while no item is in
// flight; the block itself does not enforce this. A write to an index beyond
// the three rows is ignored.
module periodic_lattice_hop_distance_core
    import phd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] dest_pos_x,
    input  logic signed [COORD_BITS-1:0] dest_pos_y,
    input  logic signed [COORD_BITS-1:0] dest_pos_z,
    input  logic signed [CELL_BITS-1:0]  dest_cell_a,
    input  logic signed [CELL_BITS-1:0]  dest_cell_b,
    input  logic signed [CELL_BITS-1:0]  dest_cell_c,
    input  logic signed [COORD_BITS-1:0] src_pos_x,
    input  logic signed [COORD_BITS-1:0] src_pos_y,
    input  logic signed [COORD_BITS-1:0] src_pos_z,
    input  logic signed [CELL_BITS-1:0]  src_cell_a,
    input  logic signed [CELL_BITS-1:0]  src_cell_b,
    input  logic signed [CELL_BITS-1:0]  src_cell_c,

    output logic                         done,
    output logic [OUT_W-1:0]             hop_length,

    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data
);

    // Lattice matrix, one row per register, column 0 in the low bits.
    logic [CFG_W-1:0] row_x_reg;
    logic [CFG_W-1:0] row_y_reg;
    logic [CFG_W-1:0] row_z_reg;

    // stage[0] is the radicand from the arithmetic front; stage[k] leaves cell k-1.
    root_stage_t stage [ROOT_W+1];

    logic accept;

    // The pipeline never stalls, so an item is always welcome.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            row_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_X: row_x_reg <= cfg_data;
                CFG_ROW_Y: row_y_reg <= cfg_data;
                CFG_ROW_Z: row_z_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Position and cell differences, matrix products, row sums, squares and the
    // sum of squares, one registered step each.
    phd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .dest_pos    ('{dest_pos_x, dest_pos_y, dest_pos_z}),
        .dest_cell   ('{dest_cell_a, dest_cell_b, dest_cell_c}),
        .src_pos     ('{src_pos_x, src_pos_y, src_pos_z}),
        .src_cell    ('{src_cell_a, src_cell_b, src_cell_c}),
        .lattice_row ('{row_x_reg, row_y_reg, row_z_reg}),
        .front_out   (stage[0])
    );

    // The integer square root, most significant root bit in the first cell.
    // Each cell hands the shifted radicand, partial remainder and partial root
    // to its neighbor every cycle, so a new item can follow in the next cycle.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        phd_root_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (stage[k]),
            .cell_out (stage[k+1])
        );
    end

    assign done       = stage[ROOT_W].valid;
    assign hop_length = stage[ROOT_W].root[OUT_W-1:0];

    // Every started item comes out after exactly the pipeline latency.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LATENCY done)
        else $error("item started but no result after the pipeline latency");

    // No result appears without an item started one pipeline latency earlier.
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LATENCY))
        else $error("result strobe without a matching started item");

    // Halfway down the root chain the valid flag matches the start history.
    a_mid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        stage[ROOT_W/2].valid |-> $past(accept, FRONT_STAGES + ROOT_W/2))
        else $error("root chain valid flag out of step with started items");

endmodule
